@@ rtl/core/kdlp_pkg.sv @@
// Package for the key debounce / long press block.
// Holds payload structs, lane result struct, phase codes and default constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kdlp_pkg;

    localparam int unsigned FIELD_W          = 4;
    localparam int unsigned COUNT_W          = 16;
    localparam int unsigned NUM_KEYS_DEFAULT = 4;
    localparam logic [COUNT_W-1:0] LONG_PRESS_RESET = 16'd70;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = {COUNT_W{1'b1}};

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_CONFIRM = 3'b010,
        PH_HELD    = 3'b100
    } t_phase;

    typedef struct packed {
        logic [FIELD_W-1:0] key_levels;
        logic [FIELD_W-1:0] clear_short;
        logic [FIELD_W-1:0] clear_long;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] short_flags;
        logic [FIELD_W-1:0] long_flags;
        logic [FIELD_W-1:0] held_keys;
    } t_out_item;

    typedef struct packed {
        logic short_hit;
        logic long_hit;
        logic held;
    } t_lane_out;

endpackage

`default_nettype wire

@@ rtl/core/key_debounce_long_press.sv @@
// Key debounce with short / long press detection, one scan tick per item.
// One lane per key runs the idle / confirm / held qualifier; the merge stage
// packs the per-key flags into the result register. A new item is taken every
// cycle while the result register is empty or being taken, so the block runs
// at one item per clock; each result is registered, valid the cycle after its
// item. Write long_press_ticks via i_cfg_we / i_cfg_data only while idle;
// not enforced. Depends on kdlp_pkg, kdlp_lane, kdlp_merge.
`timescale 1ns / 1ps
`default_nettype none

module key_debounce_long_press #(
    parameter int unsigned NUM_KEYS = kdlp_pkg::NUM_KEYS_DEFAULT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire kdlp_pkg::t_in_item             i_data,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output kdlp_pkg::t_out_item                 o_data,
    input  wire logic                           i_cfg_we,
    input  wire logic [kdlp_pkg::COUNT_W-1:0]   i_cfg_data
);

    logic [kdlp_pkg::COUNT_W-1:0]       r_long_press_ticks;
    logic                               accept;
    logic                               space;
    kdlp_pkg::t_lane_out [NUM_KEYS-1:0] lanes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_ticks <= kdlp_pkg::LONG_PRESS_RESET;
        end else if (i_cfg_we) begin
            r_long_press_ticks <= i_cfg_data;
        end
    end

    // nothing is taken while reset is held
    assign o_ready = space && i_rst_n;
    assign accept  = i_valid && o_ready;

    genvar k;
    generate
        for (k = 0; k < NUM_KEYS; k++) begin : g_lane
            logic pressed;
            logic clr_s;
            logic clr_l;
            // keys past the input width read as pressed with no clears
            if (k < kdlp_pkg::FIELD_W) begin : g_in
                assign pressed = !i_data.key_levels[k];
                assign clr_s   = i_data.clear_short[k];
                assign clr_l   = i_data.clear_long[k];
            end else begin : g_extra
                assign pressed = 1'b1;
                assign clr_s   = 1'b0;
                assign clr_l   = 1'b0;
            end
            kdlp_lane u_lane (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_accept      (accept),
                .i_pressed     (pressed),
                .i_clear_short (clr_s),
                .i_clear_long  (clr_l),
                .i_threshold   (r_long_press_ticks),
                .o_lane        (lanes[k])
            );
        end
    endgenerate

    kdlp_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_lanes (lanes),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_data  (o_data),
        .o_space (space)
    );

`ifndef SYNTHESIS
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted item produced no result");

    a_held_needs_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ((o_data.held_keys & $past(i_data.key_levels)) == '0))
        else $error("released key reported as held");

    a_no_take_without_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !accept)
        else $error("item accepted while result register full");
`endif

endmodule

`default_nettype wire

@@ rtl/core/kdlp_lane.sv @@
// One key qualifier lane: idle / confirm / held phases, hold counter, sticky flags.
// Depends on kdlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kdlp_lane (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_accept,
    input  wire logic                            i_pressed,
    input  wire logic                            i_clear_short,
    input  wire logic                            i_clear_long,
    input  wire logic [kdlp_pkg::COUNT_W-1:0]    i_threshold,
    output kdlp_pkg::t_lane_out                  o_lane
);

    kdlp_pkg::t_phase               r_phase, n_phase;
    logic [kdlp_pkg::COUNT_W-1:0]   r_count, n_count;
    logic                           r_short, n_short;
    logic                           r_long,  n_long;
    logic [kdlp_pkg::COUNT_W-1:0]   count_inc;

    assign count_inc = (r_count == kdlp_pkg::COUNT_MAX) ? r_count
                                                        : r_count + 1'b1;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_short = r_short & ~i_clear_short;
        n_long  = r_long  & ~i_clear_long;
        unique case (r_phase)
            kdlp_pkg::PH_CONFIRM: begin
                n_phase = i_pressed ? kdlp_pkg::PH_HELD : kdlp_pkg::PH_IDLE;
            end
            kdlp_pkg::PH_HELD: begin
                if (!i_pressed) begin
                    n_phase = kdlp_pkg::PH_IDLE;
                    if (r_count < i_threshold) begin
                        n_short = 1'b1;
                    end
                end else begin
                    n_count = count_inc;
                    if (count_inc > i_threshold) begin
                        n_long = 1'b1;
                    end
                end
            end
            default: begin
                n_phase = i_pressed ? kdlp_pkg::PH_CONFIRM : kdlp_pkg::PH_IDLE;
                n_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= kdlp_pkg::PH_IDLE;
            r_count <= '0;
            r_short <= 1'b0;
            r_long  <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_short <= n_short;
            r_long  <= n_long;
        end
    end

    // post-update view of this key, captured by the merge stage on accept
    assign o_lane.short_hit = n_short;
    assign o_lane.long_hit  = n_long;
    assign o_lane.held      = (n_phase == kdlp_pkg::PH_HELD);

endmodule

`default_nettype wire

@@ rtl/core/kdlp_merge.sv @@
// Merge stage: packs the lane results into one result item and holds it in
// the output register until taken. Depends on kdlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kdlp_merge #(
    parameter int unsigned NUM_KEYS = kdlp_pkg::NUM_KEYS_DEFAULT
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_load,
    input  wire kdlp_pkg::t_lane_out [NUM_KEYS-1:0] i_lanes,
    input  wire logic                      i_ready,
    output logic                           o_valid,
    output kdlp_pkg::t_out_item            o_data,
    output logic                           o_space
);

    logic                r_valid;
    kdlp_pkg::t_out_item r_data;
    kdlp_pkg::t_out_item n_data;

    genvar j;
    generate
        for (j = 0; j < kdlp_pkg::FIELD_W; j++) begin : g_pack
            if (j < NUM_KEYS) begin : g_key
                assign n_data.short_flags[j] = i_lanes[j].short_hit;
                assign n_data.long_flags[j]  = i_lanes[j].long_hit;
                assign n_data.held_keys[j]   = i_lanes[j].held;
            end else begin : g_none
                assign n_data.short_flags[j] = 1'b0;
                assign n_data.long_flags[j]  = 1'b0;
                assign n_data.held_keys[j]   = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= n_data;
        end
    end

    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire
